// File: design/prmsd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the paired-point RMSD block.
// No dependencies; used by every module under design/.
package prmsd_pkg;

    localparam int MAX_PAIRS_DEF   = 16384;
    localparam int COORD_WIDTH_DEF = 24;

    localparam int FIELD_W = 24;   // width of each coordinate port
    localparam int SUM_W   = 64;   // accumulator width
    localparam int COUNT_W = 15;   // pair counter width
    localparam int DEV_W   = 26;   // result width, unsigned Q16.10
    localparam int ROOT_W  = 32;   // full root of a 64-bit value

    typedef logic [1:0] axis_t;
    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MUL   = 5'b00010,
        ST_ADD   = 5'b00100,
        ST_START = 5'b01000,
        ST_ROOT  = 5'b10000
    } seq_state_t;

    typedef enum logic [3:0] {
        DS_IDLE = 4'b0001,
        DS_DIV  = 4'b0010,
        DS_ROOT = 4'b0100,
        DS_DONE = 4'b1000
    } dsq_state_t;

endpackage

// File: design/prmsd_sqdist.sv
`timescale 1ns / 1ps
// Squared difference of one coordinate pair with a registered product.
// Depends on prmsd_pkg.
module prmsd_sqdist #(
    parameter int COORD_WIDTH = prmsd_pkg::COORD_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic [prmsd_pkg::FIELD_W-1:0]      coord_a,
    input  logic [prmsd_pkg::FIELD_W-1:0]      coord_b,
    output logic [2*COORD_WIDTH-1:0]           square
);
    import prmsd_pkg::*;

    logic [COORD_WIDTH-1:0] a_low;
    logic [COORD_WIDTH-1:0] b_low;
    logic [COORD_WIDTH:0]   diff;
    logic [COORD_WIDTH:0]   diff_neg;
    logic [COORD_WIDTH-1:0] mag;
    logic [2*COORD_WIDTH-1:0] square_reg;
    logic [2*COORD_WIDTH-1:0] square_next;

    assign a_low    = coord_a[COORD_WIDTH-1:0];
    assign b_low    = coord_b[COORD_WIDTH-1:0];
    // sign-extend both by one bit so the difference cannot wrap
    assign diff     = {a_low[COORD_WIDTH-1], a_low} - {b_low[COORD_WIDTH-1], b_low};
    assign diff_neg = -diff;
    assign mag      = diff[COORD_WIDTH] ? diff_neg[COORD_WIDTH-1:0] : diff[COORD_WIDTH-1:0];
    assign square_next = mag * mag;

    always_ff @(posedge clk)
    begin
        square_reg <= square_next;
    end

    assign square = square_reg;

endmodule

// File: design/prmsd_divsqrt.sv
`timescale 1ns / 1ps
// Iterative mean and square root: restoring divide (one bit a cycle), then
// digit-by-digit root (two bits a cycle), both on one shared subtractor.
// Depends on prmsd_pkg.
module prmsd_divsqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          ack,
    input  logic [prmsd_pkg::SUM_W-1:0]   dividend,
    input  logic [prmsd_pkg::COUNT_W-1:0] divisor,
    output logic                          done,
    output logic [prmsd_pkg::DEV_W-1:0]   root
);
    import prmsd_pkg::*;

    localparam int SUB_W = 34;

    dsq_state_t          state_reg, state_next;
    logic [5:0]          step_reg, step_next;
    logic [SUM_W-1:0]    work_reg, work_next;
    logic [31:0]         rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [COUNT_W-1:0]  divisor_reg, divisor_next;

    logic [15:0]         div_shift;
    logic [SUB_W-1:0]    root_shift;
    logic [SUB_W-1:0]    sub_a;
    logic [SUB_W-1:0]    sub_b;
    logic [SUB_W:0]      sub_out;
    logic                borrow;

    assign div_shift  = {rem_reg[14:0], work_reg[SUM_W-1]};
    assign root_shift = {rem_reg, work_reg[SUM_W-1:SUM_W-2]};

    // shared subtractor: operands follow the phase
    always_comb
    begin
        if (state_reg == DS_ROOT)
        begin
            sub_a = root_shift;
            sub_b = {root_reg, 2'b01};
        end
        else
        begin
            sub_a = {18'd0, div_shift};
            sub_b = {19'd0, divisor_reg};
        end
    end

    assign sub_out = {1'b0, sub_a} - {1'b0, sub_b};
    assign borrow  = sub_out[SUB_W];

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        work_next    = work_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        divisor_next = divisor_reg;
        unique case (state_reg)
            DS_IDLE:
            begin
                if (start)
                begin
                    work_next    = dividend;
                    divisor_next = divisor;
                    rem_next     = '0;
                    root_next    = '0;
                    step_next    = 6'd63;
                    state_next   = DS_DIV;
                end
            end
            DS_DIV:
            begin
                if (!borrow)
                begin
                    rem_next  = {17'd0, sub_out[14:0]};
                    work_next = {work_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = {16'd0, div_shift};
                    work_next = {work_reg[SUM_W-2:0], 1'b0};
                end
                step_next = step_reg - 6'd1;
                if (step_reg == 6'd0)
                begin
                    // quotient complete: restart the remainder for the root
                    rem_next   = '0;
                    step_next  = 6'd31;
                    state_next = DS_ROOT;
                end
            end
            DS_ROOT:
            begin
                if (!borrow)
                begin
                    rem_next  = sub_out[31:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = root_shift[31:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                work_next = {work_reg[SUM_W-3:0], 2'b00};
                step_next = step_reg - 6'd1;
                if (step_reg == 6'd0)
                begin
                    state_next = DS_DONE;
                end
            end
            DS_DONE:
            begin
                // hold the root until the caller takes it
                if (ack)
                begin
                    state_next = DS_IDLE;
                end
            end
            default:
            begin
                state_next = DS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DS_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg    <= work_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        divisor_reg <= divisor_next;
    end

    assign done = (state_reg == DS_DONE);
    // clamp roots that do not fit the result field
    assign root = (root_reg[ROOT_W-1:DEV_W] != '0) ? {DEV_W{1'b1}} : root_reg[DEV_W-1:0];

endmodule

// File: design/paired_point_rmsd.sv
`timescale 1ns / 1ps
// Paired-point RMSD: each transfer brings one point of each structure in signed
// Q14.10. The block adds the squared distance to a saturating 64-bit sum and
// counts the pair; on a pair marked last_pair it returns floor(sqrt(sum/count))
// as unsigned Q16.10 with the pair count and an overflow flag, then clears its
// running state. A pair is accepted, then runs three multiply/add rounds on the
// one shared multiplier; in_stall is high meanwhile, so the next pair waits. A
// closing pair then runs the bit-serial divide and the root, both on one shared
// subtractor, before the handoff. A result sits in an output register, so the
// next set can start while it waits to be taken. Pairs beyond MAX_PAIRS are
// dropped and flagged. Depends on prmsd_pkg, prmsd_sqdist, prmsd_divsqrt.
module paired_point_rmsd #(
    parameter int MAX_PAIRS   = prmsd_pkg::MAX_PAIRS_DEF,
    parameter int COORD_WIDTH = prmsd_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [prmsd_pkg::FIELD_W-1:0] first_x,
    input  logic [prmsd_pkg::FIELD_W-1:0] first_y,
    input  logic [prmsd_pkg::FIELD_W-1:0] first_z,
    input  logic [prmsd_pkg::FIELD_W-1:0] second_x,
    input  logic [prmsd_pkg::FIELD_W-1:0] second_y,
    input  logic [prmsd_pkg::FIELD_W-1:0] second_z,
    input  logic                          last_pair,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [prmsd_pkg::DEV_W-1:0]   deviation,
    output logic [prmsd_pkg::COUNT_W-1:0] pair_total,
    output logic                          overflowed
);
    import prmsd_pkg::*;

    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_PAIRS);
    localparam int SQ_W = 2 * COORD_WIDTH;

    seq_state_t          state_reg, state_next;
    axis_t               axis_reg, axis_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                mark_reg, mark_next;
    logic                last_reg, last_next;

    // captured pair
    logic [FIELD_W-1:0]  fx_reg, fy_reg, fz_reg, sx_reg, sy_reg, sz_reg;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [DEV_W-1:0]    dev_reg;
    logic [COUNT_W-1:0]  total_reg;
    logic                ovf_reg;

    logic                in_xfer;
    logic                out_xfer;
    logic                emit;
    logic                count_full;
    logic [FIELD_W-1:0]  sel_a, sel_b;
    logic [SQ_W-1:0]     square;
    logic [SUM_W:0]      sum_wide;
    logic                dsq_start;
    logic                dsq_done;
    logic [DEV_W-1:0]    dsq_root;
    logic [COUNT_W-1:0]  divisor;

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_xfer    = in_valid && !in_stall;
    assign out_xfer   = out_valid_reg && !out_stall;
    assign count_full = (count_reg >= MAX_COUNT);
    assign dsq_start  = (state_reg == ST_START);
    // hold a finished root until the output register is free
    assign emit       = (state_reg == ST_ROOT) && dsq_done && (!out_valid_reg || !out_stall);
    assign divisor    = (count_reg == '0) ? COUNT_W'(1) : count_reg;

    // pick the coordinate pair for the current axis
    always_comb
    begin
        unique case (axis_reg)
            AXIS_X:
            begin
                sel_a = fx_reg;
                sel_b = sx_reg;
            end
            AXIS_Y:
            begin
                sel_a = fy_reg;
                sel_b = sy_reg;
            end
            AXIS_Z:
            begin
                sel_a = fz_reg;
                sel_b = sz_reg;
            end
            default:
            begin
                sel_a = fx_reg;
                sel_b = sx_reg;
            end
        endcase
    end

    prmsd_sqdist #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_sqdist (
        .clk     (clk),
        .coord_a (sel_a),
        .coord_b (sel_b),
        .square  (square)
    );

    prmsd_divsqrt u_divsqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dsq_start),
        .ack      (emit),
        .dividend (sum_reg),
        .divisor  (divisor),
        .done     (dsq_done),
        .root     (dsq_root)
    );

    assign sum_wide = {1'b0, sum_reg} + {1'b0, {(SUM_W-SQ_W){1'b0}}, square};

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        mark_next  = mark_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    last_next = last_pair;
                    if (count_full)
                    begin
                        // drop the pair, flag it, still close the set if marked
                        mark_next  = 1'b1;
                        state_next = last_pair ? ST_START : ST_IDLE;
                    end
                    else
                    begin
                        count_next = count_reg + COUNT_W'(1);
                        axis_next  = AXIS_X;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (sum_wide[SUM_W])
                begin
                    sum_next  = {SUM_W{1'b1}};
                    mark_next = 1'b1;
                end
                else
                begin
                    sum_next = sum_wide[SUM_W-1:0];
                end
                if (axis_reg == AXIS_Z)
                begin
                    state_next = last_reg ? ST_START : ST_IDLE;
                end
                else
                begin
                    axis_next  = axis_reg + axis_t'(1);
                    state_next = ST_MUL;
                end
            end
            ST_START:
            begin
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (emit)
                begin
                    sum_next   = '0;
                    count_next = '0;
                    mark_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= AXIS_X;
            sum_reg       <= '0;
            count_reg     <= '0;
            mark_reg      <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            mark_reg      <= mark_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers: capture on input transfer, load on emit
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            fx_reg <= first_x;
            fy_reg <= first_y;
            fz_reg <= first_z;
            sx_reg <= second_x;
            sy_reg <= second_y;
            sz_reg <= second_z;
        end
        if (emit)
        begin
            dev_reg   <= dsq_root;
            total_reg <= count_reg;
            ovf_reg   <= mark_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign deviation  = dev_reg;
    assign pair_total = total_reg;
    assign overflowed = ovf_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_COUNT)
        else $error("pair count above limit");

    a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> sum_reg == '0)
        else $error("nonzero sum with no pairs counted");

    a_done_in_root: assert property (@(posedge clk) disable iff (!rst_n)
        dsq_done |-> state_reg == ST_ROOT)
        else $error("root finished outside root wait");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg && count_reg == '0 && !mark_reg)
        else $error("emit did not present result and clear state");

    a_emit_open: assert property (@(posedge clk) disable iff (!rst_n)
        emit && out_valid_reg |-> !out_stall)
        else $error("result overwritten while stalled");
`endif

endmodule
